[rtl/lea_pkg.sv]
// Shared types, codes and round functions for the LEA-128 round engine.
// Depends on nothing; used by lea_block_cipher_rounds_core.
package lea_pkg;

    localparam int WORD_W     = 32;
    localparam int KEY_WORDS  = 6;
    localparam int BLK_WORDS  = 4;
    localparam int RIDX_W     = 5;
    localparam int WIDX_W     = 3;
    localparam int ROT_A      = 9;
    localparam int ROT_B      = 5;
    localparam int ROT_C      = 3;

    typedef logic [WORD_W-1:0]                word_t;
    typedef logic [BLK_WORDS-1:0][WORD_W-1:0] block_t;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_row_t;

    typedef enum logic [1:0] {
        ACT_LOAD_ENC = 2'd0,
        ACT_LOAD_DEC = 2'd1,
        ACT_ENCRYPT  = 2'd2,
        ACT_DECRYPT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_RUN   = 2'd2,
        ST_FLUSH = 2'd3
    } state_t;

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic block_t fwd_round(input block_t w, input key_row_t k);
        block_t r;
        r[0] = rotl((w[0] ^ k[0]) + (w[1] ^ k[1]), ROT_A);
        r[1] = rotr((w[1] ^ k[2]) + (w[2] ^ k[3]), ROT_B);
        r[2] = rotr((w[2] ^ k[4]) + (w[3] ^ k[5]), ROT_C);
        r[3] = w[0];
        fwd_round = r;
    endfunction

    function automatic block_t inv_round(input block_t w, input key_row_t k);
        block_t r;
        r[0] = w[3];
        r[1] = (rotr(w[0], ROT_A) - (r[0] ^ k[0])) ^ k[1];
        r[2] = (rotl(w[1], ROT_B) - (r[1] ^ k[2])) ^ k[3];
        r[3] = (rotl(w[2], ROT_C) - (r[2] ^ k[4])) ^ k[5];
        inv_round = r;
    endfunction

endpackage

[rtl/lea_block_cipher_rounds_core.sv]
// LEA-128 round engine: key-row memories, round sequencer and result register.
// Depends on lea_pkg (types, action and state codes, round functions).
//
// One round unit is applied once per round, forward or inverse, with the six
// key words of that round read as one row from the encryption or decryption
// key memory (ROUNDS rows of six 32-bit words, one row read per cycle with a
// registered read). A key-load word gives no result; an encrypt or decrypt
// word passes from its acceptance to the acceptance of the next word through
// a fetch state for the first key row, a run state for the ROUNDS rounds
// through the round unit, a flush state that moves the block into the result
// register, and the idle state in which the next word is taken. The result
// register frees the engine, so a new word may be accepted while the last
// result waits to be taken; the move into the result register waits while an
// older result is still held there. Key memories are not cleared; load every
// key word of a round set before using it.
module lea_block_cipher_rounds_core #(
    parameter int ROUNDS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [4:0] round_index, [7:5] word_index, [39:8] key_word,
    // [71:40] block_word0, [103:72] block_word1,
    // [135:104] block_word2, [167:136] block_word3
    input  logic [167:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] out_word0, [63:32] out_word1, [95:64] out_word2, [127:96] out_word3
    output logic [127:0] m_axis_tdata
);

    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    lea_pkg::state_t   state_reg, state_next;
    lea_pkg::block_t   blk_reg, blk_next;
    lea_pkg::block_t   out_blk_reg;
    lea_pkg::key_row_t enc_row_reg, dec_row_reg, key_row;
    logic [RW-1:0]     round_reg, round_next, rd_addr;
    logic              dec_mode_reg, dec_mode_next;
    logic              out_valid_reg;
    logic              rd_en, out_load, last_round;
    logic              in_fire, is_crypt, key_ok, enc_we, dec_we;

    lea_pkg::action_t      action;
    logic [lea_pkg::RIDX_W-1:0] round_index;
    logic [lea_pkg::WIDX_W-1:0] word_index;
    lea_pkg::word_t        key_word;
    lea_pkg::block_t       in_blk;

    lea_pkg::key_row_t enc_mem [ROUNDS];
    lea_pkg::key_row_t dec_mem [ROUNDS];

    assign action      = lea_pkg::action_t'(s_axis_tuser);
    assign round_index = s_axis_tdata[4:0];
    assign word_index  = s_axis_tdata[7:5];
    assign key_word    = s_axis_tdata[39:8];
    assign in_blk      = s_axis_tdata[167:40];

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign is_crypt = (action == lea_pkg::ACT_ENCRYPT) || (action == lea_pkg::ACT_DECRYPT);
    // drop loads outside the key memory
    assign key_ok   = ({1'b0, round_index} < 6'(ROUNDS))
                   && (word_index < 3'(lea_pkg::KEY_WORDS));
    assign enc_we   = in_fire && key_ok && (action == lea_pkg::ACT_LOAD_ENC);
    assign dec_we   = in_fire && key_ok && (action == lea_pkg::ACT_LOAD_DEC);

    assign last_round = (round_reg == RW'(ROUNDS - 1));
    // prefetch the next row while the current one is in use
    assign rd_addr = (state_reg == lea_pkg::ST_FETCH || last_round) ? round_reg
                                                                   : round_reg + RW'(1);

    always_ff @(posedge clk)
    begin
        if (enc_we)
        begin
            enc_mem[round_index[RW-1:0]][word_index] <= key_word;
        end
        if (rd_en)
        begin
            enc_row_reg <= enc_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_we)
        begin
            dec_mem[round_index[RW-1:0]][word_index] <= key_word;
        end
        if (rd_en)
        begin
            dec_row_reg <= dec_mem[rd_addr];
        end
    end

    assign key_row = dec_mode_reg ? dec_row_reg : enc_row_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lea_pkg::ST_IDLE:
            begin
                if (in_fire && is_crypt)
                begin
                    state_next = lea_pkg::ST_FETCH;
                end
            end
            lea_pkg::ST_FETCH:
            begin
                state_next = lea_pkg::ST_RUN;
            end
            lea_pkg::ST_RUN:
            begin
                if (last_round)
                begin
                    state_next = lea_pkg::ST_FLUSH;
                end
            end
            lea_pkg::ST_FLUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = lea_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lea_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        round_next    = round_reg;
        blk_next      = blk_reg;
        dec_mode_next = dec_mode_reg;
        case (state_reg)
            lea_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_fire && is_crypt)
                begin
                    blk_next      = in_blk;
                    dec_mode_next = (action == lea_pkg::ACT_DECRYPT);
                    round_next    = '0;
                end
            end
            lea_pkg::ST_FETCH:
            begin
                rd_en = 1'b1;
            end
            lea_pkg::ST_RUN:
            begin
                rd_en      = !last_round;
                blk_next   = dec_mode_reg ? lea_pkg::inv_round(blk_reg, key_row)
                                          : lea_pkg::fwd_round(blk_reg, key_row);
                round_next = last_round ? round_reg : round_reg + RW'(1);
            end
            lea_pkg::ST_FLUSH:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lea_pkg::ST_IDLE;
            round_reg     <= '0;
            dec_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            dec_mode_reg <= dec_mode_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (out_load)
        begin
            out_blk_reg <= blk_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_blk_reg;

    a_fetch_then_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lea_pkg::ST_FETCH |=> state_reg == lea_pkg::ST_RUN)
        else $error("key fetch not followed by round");

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= RW'(ROUNDS - 1))
        else $error("round counter out of range");

    a_result_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == lea_pkg::ST_FLUSH)
        else $error("result raised outside flush");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lea_pkg::ST_RUN) |-> !s_axis_tready)
        else $error("input ready while rounds run");

endmodule

[tb/tb.sv]
// Self-checking bench for the LEA-128 round engine: key loads, encrypt and decrypt words.
// Depends on lea_pkg and lea_block_cipher_rounds_core; keeps its own key stores and round
// arithmetic to predict every result block whose expected value the table does not give.
`timescale 1ns / 100ps

module tb;

    localparam int ROUNDS     = 24;
    localparam int KEY_WORDS  = lea_pkg::KEY_WORDS;
    localparam int BLK_WORDS  = lea_pkg::BLK_WORDS;
    localparam int RIDX_W     = lea_pkg::RIDX_W;
    localparam int WIDX_W     = lea_pkg::WIDX_W;
    localparam int KEY_DEPTH  = ROUNDS * KEY_WORDS;
    localparam int DIR_ROWS   = 21;
    localparam int RAND_WORDS = 150;
    localparam int DRAIN      = 2 * (ROUNDS + 3) + 10;

    typedef struct {
        lea_pkg::action_t  act;
        logic [RIDX_W-1:0] rnd;
        logic [WIDX_W-1:0] wrd;
        lea_pkg::word_t    key;
        lea_pkg::block_t   blk;
        bit                known;
        lea_pkg::block_t   want;
    } vec_t;

    logic         clk;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = lea_pkg::ACT_LOAD_ENC;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;

    lea_pkg::word_t  enc_keys [KEY_DEPTH];
    lea_pkg::word_t  dec_keys [KEY_DEPTH];
    lea_pkg::block_t pending_blocks [$];
    vec_t            dir_tab [DIR_ROWS];
    bit              calm   = 1'b0;
    int              errors = 0;

    lea_block_cipher_rounds_core #(
        .ROUNDS(ROUNDS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // ARX rounds over the whole key set, forward for encrypt, inverse for decrypt
    function automatic lea_pkg::block_t run_rounds(input lea_pkg::action_t act,
                                                   input lea_pkg::block_t blk);
        lea_pkg::block_t w;
        lea_pkg::block_t n;
        lea_pkg::word_t  s;
        lea_pkg::word_t  k [KEY_WORDS];
        w = blk;
        for (int r = 0; r < ROUNDS; r++)
        begin
            for (int j = 0; j < KEY_WORDS; j++)
            begin
                if (act == lea_pkg::ACT_ENCRYPT)
                    k[j] = enc_keys[r*KEY_WORDS+j];
                else
                    k[j] = dec_keys[r*KEY_WORDS+j];
            end
            if (act == lea_pkg::ACT_ENCRYPT)
            begin
                s    = (w[0] ^ k[0]) + (w[1] ^ k[1]);
                n[0] = {s[22:0], s[31:23]};
                s    = (w[1] ^ k[2]) + (w[2] ^ k[3]);
                n[1] = {s[4:0], s[31:5]};
                s    = (w[2] ^ k[4]) + (w[3] ^ k[5]);
                n[2] = {s[2:0], s[31:3]};
                n[3] = w[0];
            end
            else
            begin
                n[0] = w[3];
                n[1] = ({w[0][8:0], w[0][31:9]} - (n[0] ^ k[0])) ^ k[1];
                n[2] = ({w[1][26:0], w[1][31:27]} - (n[1] ^ k[2])) ^ k[3];
                n[3] = ({w[2][28:0], w[2][31:29]} - (n[2] ^ k[4])) ^ k[5];
            end
            w = n;
        end
        return w;
    endfunction

    function automatic lea_pkg::word_t pick_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Hold the word until taken, then update the key stores or queue the block it will give
    task automatic send_word(input vec_t v);
        while (!calm && $urandom_range(99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= v.act;
        s_axis_tdata  <= {v.blk, v.key, v.wrd, v.rnd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (v.act)
            lea_pkg::ACT_LOAD_ENC, lea_pkg::ACT_LOAD_DEC:
            begin
                if (v.rnd < ROUNDS && v.wrd < KEY_WORDS)
                begin
                    if (v.act == lea_pkg::ACT_LOAD_ENC)
                        enc_keys[v.rnd*KEY_WORDS+v.wrd] = v.key;
                    else
                        dec_keys[v.rnd*KEY_WORDS+v.wrd] = v.key;
                end
            end
            default:
                pending_blocks.push_back(v.known ? v.want : run_rounds(v.act, v.blk));
        endcase
    endtask

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 11);

    always @(posedge clk)
    begin
        lea_pkg::block_t got;
        lea_pkg::block_t exp_blk;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected result block %h", $time, got);
                errors++;
            end
            else
            begin
                exp_blk = pending_blocks.pop_front();
                for (int j = 0; j < BLK_WORDS; j++)
                begin
                    if (got[j] !== exp_blk[j])
                    begin
                        $display("%0t: out_word%0d expected %h actual %h",
                                 $time, j, exp_blk[j], got[j]);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        vec_t            v;
        lea_pkg::block_t ones;
        lea_pkg::block_t edge_blk;
        int              kind;

        ones     = '1;
        edge_blk = {32'hffff_fffe, 32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000};

        // With all keys zero every round maps the zero block to itself
        dir_tab[0]  = '{lea_pkg::ACT_ENCRYPT,  5'd0,  3'd0, '0,            '0,       1'b1, '0};
        dir_tab[1]  = '{lea_pkg::ACT_DECRYPT,  5'd0,  3'd0, '0,            '0,       1'b1, '0};
        dir_tab[2]  = '{lea_pkg::ACT_ENCRYPT,  5'd31, 3'd7, 32'hffff_ffff, '0,       1'b1, '0};
        // Loads out of range must leave the stores alone
        dir_tab[3]  = '{lea_pkg::ACT_LOAD_ENC, 5'd24, 3'd0, 32'hffff_ffff, '0,       1'b0, '0};
        dir_tab[4]  = '{lea_pkg::ACT_LOAD_ENC, 5'd31, 3'd5, 32'hffff_ffff, '0,       1'b0, '0};
        dir_tab[5]  = '{lea_pkg::ACT_LOAD_ENC, 5'd0,  3'd6, 32'hffff_ffff, '0,       1'b0, '0};
        dir_tab[6]  = '{lea_pkg::ACT_LOAD_DEC, 5'd23, 3'd7, 32'hffff_ffff, ones,     1'b0, '0};
        dir_tab[7]  = '{lea_pkg::ACT_ENCRYPT,  5'd0,  3'd0, '0,            '0,       1'b1, '0};
        dir_tab[8]  = '{lea_pkg::ACT_DECRYPT,  5'd0,  3'd0, '0,            '0,       1'b1, '0};
        dir_tab[9]  = '{lea_pkg::ACT_ENCRYPT,  5'd0,  3'd0, '0,            ones,     1'b0, '0};
        dir_tab[10] = '{lea_pkg::ACT_DECRYPT,  5'd0,  3'd0, '0,            ones,     1'b0, '0};
        dir_tab[11] = '{lea_pkg::ACT_LOAD_ENC, 5'd0,  3'd0, 32'hffff_ffff, ones,     1'b0, '0};
        dir_tab[12] = '{lea_pkg::ACT_LOAD_ENC, 5'd23, 3'd5, 32'hffff_ffff, '0,       1'b0, '0};
        dir_tab[13] = '{lea_pkg::ACT_LOAD_DEC, 5'd0,  3'd5, 32'h8000_0000, '0,       1'b0, '0};
        dir_tab[14] = '{lea_pkg::ACT_LOAD_DEC, 5'd23, 3'd0, 32'h0000_0001, '0,       1'b0, '0};
        dir_tab[15] = '{lea_pkg::ACT_ENCRYPT,  5'd0,  3'd0, '0,            '0,       1'b0, '0};
        dir_tab[16] = '{lea_pkg::ACT_ENCRYPT,  5'd31, 3'd7, 32'hffff_ffff, ones,     1'b0, '0};
        dir_tab[17] = '{lea_pkg::ACT_DECRYPT,  5'd0,  3'd0, '0,            '0,       1'b0, '0};
        dir_tab[18] = '{lea_pkg::ACT_DECRYPT,  5'd31, 3'd7, 32'hffff_ffff, ones,     1'b0, '0};
        dir_tab[19] = '{lea_pkg::ACT_ENCRYPT,  5'd0,  3'd0, '0,            edge_blk, 1'b0, '0};
        dir_tab[20] = '{lea_pkg::ACT_DECRYPT,  5'd0,  3'd0, '0,            edge_blk, 1'b0, '0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill both key stores with zeros so no unwritten word is ever read
        for (int k = 0; k < 2 * KEY_DEPTH; k++)
        begin
            v = '{(k < KEY_DEPTH) ? lea_pkg::ACT_LOAD_ENC : lea_pkg::ACT_LOAD_DEC,
                  RIDX_W'((k % KEY_DEPTH) / KEY_WORDS), WIDX_W'(k % KEY_WORDS),
                  '0, '0, 1'b0, '0};
            send_word(v);
        end

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_tab[i]);

        // Random key sets in both stores before the mixed traffic
        for (int k = 0; k < 2 * KEY_DEPTH; k++)
        begin
            v = '{(k < KEY_DEPTH) ? lea_pkg::ACT_LOAD_ENC : lea_pkg::ACT_LOAD_DEC,
                  RIDX_W'((k % KEY_DEPTH) / KEY_WORDS), WIDX_W'(k % KEY_WORDS),
                  pick_word(), {$urandom(), $urandom(), $urandom(), $urandom()}, 1'b0, '0};
            send_word(v);
        end

        for (int i = 0; i < RAND_WORDS; i++)
        begin
            calm = (i >= 50 && i < 100);
            v.rnd   = RIDX_W'($urandom());
            v.wrd   = WIDX_W'($urandom());
            v.key   = pick_word();
            v.blk   = {pick_word(), pick_word(), pick_word(), pick_word()};
            v.known = 1'b0;
            v.want  = '0;
            kind    = int'($urandom_range(99));
            if (kind < 35)
            begin
                v.act = $urandom_range(1) ? lea_pkg::ACT_LOAD_DEC : lea_pkg::ACT_LOAD_ENC;
                if (kind < 30)
                begin
                    v.rnd = RIDX_W'($urandom_range(ROUNDS - 1));
                    v.wrd = WIDX_W'($urandom_range(KEY_WORDS - 1));
                end
                else if (kind < 33)
                    v.rnd = RIDX_W'($urandom_range(31, ROUNDS));
                else
                    v.wrd = WIDX_W'($urandom_range(7, KEY_WORDS));
            end
            else
                v.act = $urandom_range(1) ? lea_pkg::ACT_DECRYPT : lea_pkg::ACT_ENCRYPT;
            send_word(v);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
